>>> rtl/cv_scale_quantizer_unit_defines.svh
// ---------------------------------------------------------------------------
// cv_scale_quantizer_unit_defines.svh
// Assertion macros for the CV scale quantizer.
// ---------------------------------------------------------------------------
`ifndef CV_SCALE_QUANTIZER_UNIT_DEFINES_SVH
`define CV_SCALE_QUANTIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CSQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/csq_pkg.sv
// ---------------------------------------------------------------------------
// csq_pkg
// Scale tables, note values and register indexes for the CV scale quantizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package csq_pkg;

    localparam int NUM_SCALES = 8;
    localparam int MAX_NOTES  = 12;

    typedef logic [3:0]  semitone_t;
    typedef logic [11:0] note_val_t;
    typedef logic [2:0]  scale_sel_t;
    typedef logic [1:0]  cfg_addr_t;

    localparam cfg_addr_t REG_SCALE_OFFSET      = 2'd0;
    localparam cfg_addr_t REG_TRANSPOSE_OFFSET  = 2'd1;
    localparam cfg_addr_t REG_GATE_THRESHOLD    = 2'd2;
    localparam cfg_addr_t REG_TRIGGER_CONNECTED = 2'd3;

    localparam logic signed [15:0] GATE_THRESHOLD_RESET = 16'sd2048;

    // Semitone count that closes the octave (cutoff above the last note)
    localparam semitone_t OCTAVE_SEMITONES = 4'd12;

    localparam semitone_t SCALE_LEN [NUM_SCALES] = '{
        4'd1, 4'd12, 4'd7, 4'd7, 4'd5, 4'd5, 4'd5, 4'd7
    };

    // Unused entries past each scale's length are zero and masked by SCALE_LEN
    localparam semitone_t SCALE_NOTES [NUM_SCALES][MAX_NOTES] = '{
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
    };

    // round(semitone * 4096 / 12) in Q4.12
    localparam note_val_t NOTE_VALUE [MAX_NOTES] = '{
        12'd0, 12'd341, 12'd683, 12'd1024, 12'd1365, 12'd1707,
        12'd2048, 12'd2389, 12'd2731, 12'd3072, 12'd3413, 12'd3755
    };

endpackage

>>> rtl/cv_scale_quantizer_unit.sv
// ---------------------------------------------------------------------------
// cv_scale_quantizer_unit
// Pitch quantizer for 1 V/octave control voltages in signed Q4.12.
// ---------------------------------------------------------------------------
// Takes one input word per clock unless the output stalls and returns one
// result word per input word: an input register feeds a single pass of
// transpose/saturate, scale select, twelve parallel cutoff compares and a
// priority pick into the result register, so sustained rate is one word per
// cycle with back-pressure passed through both stages. Configuration writes
// take effect at once and must be made while no word is in flight.
`timescale 1ns / 1ps

`include "cv_scale_quantizer_unit_defines.svh"

module cv_scale_quantizer_unit
    import csq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] pitch_cv,
    input  logic signed [15:0] scale_cv,
    input  logic signed [15:0] transpose_cv,
    input  logic signed [15:0] trigger_cv,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] quantized_cv,
    output logic               note_changed
);

    // Configuration
    logic [14:0]        scale_offset_reg;
    logic signed [15:0] transpose_offset_reg;
    logic signed [15:0] gate_threshold_reg;
    logic               trigger_connected_reg;

    // Input stage
    logic               s1_valid_reg;
    logic signed [15:0] s1_pitch_reg;
    logic signed [15:0] s1_scale_reg;
    logic signed [15:0] s1_transpose_reg;
    logic signed [15:0] s1_trigger_reg;

    // Result stage
    logic               out_valid_reg;
    logic signed [15:0] out_q_reg;
    logic               out_changed_reg;

    // Running state
    logic signed [15:0] last_quantized_reg;
    logic               have_last_reg;
    logic               prev_trigger_high_reg;

    logic               advance;
    logic               in_fire;

    logic signed [17:0] pitch_sum;
    logic signed [15:0] pitch_sat;
    logic signed [16:0] scale_sum;
    scale_sel_t         sel;
    logic signed [3:0]  octave;
    logic [11:0]        frac;
    logic [13:0]        frac3;
    logic [4:0]         cut [MAX_NOTES];
    logic [MAX_NOTES-1:0] hit;
    logic               found;
    semitone_t          note;
    logic signed [15:0] q_new;
    logic               trig_high;
    logic               sample;
    logic               prev_trigger_high_next;
    logic signed [15:0] q_next;
    logic               changed_next;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign out_valid    = out_valid_reg;
    assign quantized_cv = out_q_reg;
    assign note_changed = out_changed_reg;

    // Pitch: sum and saturate to 16 bits
    assign pitch_sum = {{2{s1_pitch_reg[15]}}, s1_pitch_reg}
                     + {{2{transpose_offset_reg[15]}}, transpose_offset_reg}
                     + {{2{s1_transpose_reg[15]}}, s1_transpose_reg};

    always_comb
    begin
        if (pitch_sum > 18'sd32767)
            pitch_sat = 16'sh7fff;
        else if (pitch_sum < -18'sd32768)
            pitch_sat = 16'sh8000;
        else
            pitch_sat = pitch_sum[15:0];
    end

    // Scale select: floor to volts, clamp to 0..7
    assign scale_sum = $signed({2'b00, scale_offset_reg}) + $signed({s1_scale_reg[15], s1_scale_reg});

    always_comb
    begin
        if (scale_sum[16])
            sel = 3'd0;
        else if (scale_sum[15])
            sel = 3'd7;
        else
            sel = scale_sum[14:12];
    end

    assign octave = pitch_sat[15:12];
    assign frac   = pitch_sat[11:0];
    // frac*24 < c*4096 reduces to frac*3 < c*512
    assign frac3  = {2'b00, frac} + {1'b0, frac, 1'b0};

    always_comb
    begin
        for (int i = 0; i < MAX_NOTES - 1; i++)
        begin
            if (4'(i + 1) < SCALE_LEN[sel])
                cut[i] = {1'b0, SCALE_NOTES[sel][i]} + {1'b0, SCALE_NOTES[sel][i + 1]};
            else
                cut[i] = {1'b0, SCALE_NOTES[sel][i]} + {1'b0, OCTAVE_SEMITONES};
        end
        cut[MAX_NOTES - 1] = {1'b0, SCALE_NOTES[sel][MAX_NOTES - 1]} + {1'b0, OCTAVE_SEMITONES};

        for (int i = 0; i < MAX_NOTES; i++)
            hit[i] = (4'(i) < SCALE_LEN[sel]) && (frac3 < {cut[i], 9'b0});

        // Lowest hit wins
        found = 1'b0;
        note  = '0;
        for (int i = MAX_NOTES - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                found = 1'b1;
                note  = SCALE_NOTES[sel][i];
            end
        end

        if (found)
            q_new = {octave, NOTE_VALUE[note]};
        else if (octave == 4'sd7)
            q_new = 16'sh7fff;
        else
            q_new = {octave + 4'sd1, 12'b0};
    end

    // Trigger gating and change detect
    always_comb
    begin
        trig_high = s1_trigger_reg >= gate_threshold_reg;
        if (trigger_connected_reg)
        begin
            sample                 = trig_high && !prev_trigger_high_reg;
            prev_trigger_high_next = trig_high;
        end
        else
        begin
            sample                 = 1'b1;
            prev_trigger_high_next = gate_threshold_reg[15] || (gate_threshold_reg == 16'sd0);
        end

        if (sample)
        begin
            q_next       = q_new;
            changed_next = !have_last_reg || (q_new != last_quantized_reg);
        end
        else
        begin
            q_next       = last_quantized_reg;
            changed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_offset_reg      <= '0;
            transpose_offset_reg  <= '0;
            gate_threshold_reg    <= GATE_THRESHOLD_RESET;
            trigger_connected_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_SCALE_OFFSET:      scale_offset_reg      <= cfg_wdata[14:0];
                REG_TRANSPOSE_OFFSET:  transpose_offset_reg  <= cfg_wdata;
                REG_GATE_THRESHOLD:    gate_threshold_reg    <= cfg_wdata;
                REG_TRIGGER_CONNECTED: trigger_connected_reg <= cfg_wdata[0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            last_quantized_reg    <= '0;
            have_last_reg         <= 1'b0;
            prev_trigger_high_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg         <= 1'b1;
                last_quantized_reg    <= q_next;
                have_last_reg         <= have_last_reg || sample;
                prev_trigger_high_reg <= prev_trigger_high_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pitch_reg     <= pitch_cv;
            s1_scale_reg     <= scale_cv;
            s1_transpose_reg <= transpose_cv;
            s1_trigger_reg   <= trigger_cv;
        end
        if (advance)
        begin
            out_q_reg       <= q_next;
            out_changed_reg <= changed_next;
        end
    end

    `CSQ_ASSERT_NOW(a_out_tracks_last, out_valid_reg, out_q_reg == last_quantized_reg, "result word differs from held value")
    `CSQ_ASSERT_NOW(a_changed_needs_sample, out_valid_reg && out_changed_reg, have_last_reg, "change flagged with no sample taken")
    `CSQ_ASSERT_NEXT(a_stall_keeps_input, s1_valid_reg && out_valid_reg && !out_ready, s1_valid_reg, "input word dropped under stall")

endmodule

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CV scale quantizer: a directed table covers
// pitch and transpose extremes, every scale and the trigger hold cases, then
// random words run under several register settings and idle patterns, each
// result checked against a cycle-free model of the quantizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import csq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETS_PER_PASS  = 6;
    localparam int WORDS_PER_SET  = 60;
    localparam int PLAN_ROWS      = 35;

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] scv;
        logic signed [15:0] tcv;
        logic signed [15:0] trig;
    } cv_word_t;

    typedef struct {
        logic signed [15:0] q;
        logic               changed;
    } note_t;

    typedef enum bit { ROW_REG, ROW_WORD } row_kind_t;

    // Register rows: f0 = index, f1 = data. Word rows: pitch, scale, transpose, trigger.
    typedef struct {
        row_kind_t kind;
        int        f0;
        int        f1;
        int        f2;
        int        f3;
        bit        typed;
        int        want_q;
        bit        want_chg;
    } plan_row_t;

    localparam int SCALE_SIZE [8] = '{1, 12, 7, 7, 5, 5, 5, 7};
    localparam int SCALE_STEPS [8][12] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11},
        '{0, 2, 4, 5, 7, 9, 11, 0, 0, 0, 0, 0},
        '{0, 2, 3, 5, 7, 8, 10, 0, 0, 0, 0, 0},
        '{0, 2, 4, 7, 9, 0, 0, 0, 0, 0, 0, 0},
        '{0, 3, 5, 7, 10, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1, 5, 7, 10, 0, 0, 0, 0, 0, 0, 0},
        '{0, 2, 3, 5, 7, 9, 10, 0, 0, 0, 0, 0}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    cfg_addr_t          cfg_addr;
    logic [15:0]        cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] pitch_cv;
    logic signed [15:0] scale_cv;
    logic signed [15:0] transpose_cv;
    logic signed [15:0] trigger_cv;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] quantized_cv;
    logic               note_changed;

    // Register shadow and quantizer state
    logic [14:0]        scale_off_reg  = '0;
    logic signed [15:0] transpose_reg  = '0;
    logic signed [15:0] threshold_reg  = 16'sd2048;
    logic               trig_mode_reg  = 1'b0;
    logic signed [15:0] held_note      = '0;
    bit                 have_note      = 1'b0;
    bit                 trig_was_high  = 1'b0;

    note_t pending_notes [$];
    int    mismatch_count = 0;
    int    idle_cycles    = 0;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;

    plan_row_t opening_plan [PLAN_ROWS] = '{
        '{ROW_REG,  int'(REG_TRIGGER_CONNECTED), 1, 0, 0, 0, 0, 0},
        '{ROW_WORD, 0, 0, 0, 0, 1, 0, 0},
        '{ROW_WORD, 0, 0, 0, 2048, 1, 0, 1},
        '{ROW_WORD, 4096, 0, 0, 32767, 1, 0, 0},
        '{ROW_WORD, 4096, 0, 0, 2047, 1, 0, 0},
        '{ROW_WORD, 4096, 0, 0, 2048, 1, 4096, 1},
        '{ROW_REG,  int'(REG_TRIGGER_CONNECTED), 0, 0, 0, 0, 0, 0},
        '{ROW_WORD, 4096, 0, 0, 0, 1, 4096, 0},
        '{ROW_WORD, 32767, 0, 0, 0, 1, 32767, 1},
        '{ROW_WORD, -32768, 0, 0, 0, 1, -32768, 1},
        '{ROW_WORD, 2047, 0, 0, 0, 1, 0, 1},
        '{ROW_WORD, 2048, 0, 0, 0, 1, 4096, 1},
        '{ROW_WORD, 32767, 0, 32767, 0, 1, 32767, 1},
        '{ROW_WORD, -32768, 0, -32768, 0, 1, -32768, 1},
        '{ROW_WORD, 1000, -32768, 0, 0, 1, 0, 1},
        '{ROW_WORD, 341, 4096, 0, 0, 0, 0, 0},
        '{ROW_WORD, 1400, 8192, 0, 0, 0, 0, 0},
        '{ROW_WORD, 1400, 12288, 0, -32768, 0, 0, 0},
        '{ROW_WORD, 2000, 16384, 100, 0, 0, 0, 0},
        '{ROW_WORD, 2500, 20480, -200, 0, 0, 0, 0},
        '{ROW_WORD, 3000, 24576, 0, 0, 0, 0, 0},
        '{ROW_WORD, 3900, 32767, 0, 0, 0, 0, 0},
        '{ROW_REG,  int'(REG_SCALE_OFFSET), 32767, 0, 0, 0, 0, 0},
        '{ROW_WORD, 3900, 32767, 0, 0, 0, 0, 0},
        '{ROW_REG,  int'(REG_TRANSPOSE_OFFSET), -32768, 0, 0, 0, 0, 0},
        '{ROW_WORD, -100, 0, 0, 0, 0, 0, 0},
        '{ROW_REG,  int'(REG_TRANSPOSE_OFFSET), 32767, 0, 0, 0, 0, 0},
        '{ROW_WORD, 100, 0, 0, 0, 0, 0, 0},
        '{ROW_REG,  int'(REG_GATE_THRESHOLD), -32768, 0, 0, 0, 0, 0},
        '{ROW_WORD, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_REG,  int'(REG_TRIGGER_CONNECTED), 1, 0, 0, 0, 0, 0},
        '{ROW_WORD, 0, 0, 0, -32768, 0, 0, 0},
        '{ROW_REG,  int'(REG_GATE_THRESHOLD), 32767, 0, 0, 0, 0, 0},
        '{ROW_WORD, 5000, 0, 0, 32766, 0, 0, 0},
        '{ROW_WORD, -5000, 0, 0, 32767, 0, 0, 0}
    };

    cv_scale_quantizer_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pitch_cv     (pitch_cv),
        .scale_cv     (scale_cv),
        .transpose_cv (transpose_cv),
        .trigger_cv   (trigger_cv),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .quantized_cv (quantized_cv),
        .note_changed (note_changed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp16(int x);
        if (x > 32767)
            return 32767;
        if (x < -32768)
            return -32768;
        return x;
    endfunction

    // Snap a pitch to the nearest note of the selected scale, midpoint cutoffs
    function automatic int snap_pitch(int p, int sel);
        int octave;
        int frac;
        int lo;
        int hi;
        int n;
        octave = ((p + 32768) >> 12) - 8;
        frac   = p - octave * 4096;
        for (n = 0; n < SCALE_SIZE[sel]; n++)
        begin
            lo = SCALE_STEPS[sel][n];
            hi = (n + 1 < SCALE_SIZE[sel]) ? SCALE_STEPS[sel][n + 1] : 12;
            if (frac * 24 < (lo + hi) * 4096)
                return clamp16(octave * 4096 + (lo * 4096 + 6) / 12);
        end
        return clamp16((octave + 1) * 4096);
    endfunction

    function automatic note_t next_note(cv_word_t w);
        bit    take;
        bit    high;
        int    ssum;
        int    sel;
        int    q;
        note_t r;
        if (trig_mode_reg)
        begin
            high          = (w.trig >= threshold_reg);
            take          = high && !trig_was_high;
            trig_was_high = high;
        end
        else
        begin
            take          = 1'b1;
            // level of a trigger input resting at 0 V
            trig_was_high = (threshold_reg <= 0);
        end
        r.q       = held_note;
        r.changed = 1'b0;
        if (take)
        begin
            ssum = int'(scale_off_reg) + int'(w.scv);
            sel  = (ssum < 0) ? 0 : (((ssum >> 12) > 7) ? 7 : (ssum >> 12));
            q    = snap_pitch(clamp16(int'(w.pitch) + int'(transpose_reg) + int'(w.tcv)), sel);
            r.q       = 16'(q);
            r.changed = !have_note || (r.q != held_note);
            held_note = r.q;
            have_note = 1'b1;
        end
        return r;
    endfunction

    task automatic write_reg(cfg_addr_t idx, logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SCALE_OFFSET:      scale_off_reg = data[14:0];
            REG_TRANSPOSE_OFFSET:  transpose_reg = data;
            REG_GATE_THRESHOLD:    threshold_reg = data;
            REG_TRIGGER_CONNECTED: trig_mode_reg = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic push_word(cv_word_t w, bit typed, note_t want);
        note_t got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        pitch_cv     <= w.pitch;
        scale_cv     <= w.scv;
        transpose_cv <= w.tcv;
        trigger_cv   <= w.trig;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        got = next_note(w);
        pending_notes.push_back(typed ? want : got);
    endtask

    // Drop valid and wait until the pipeline is empty
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_notes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        note_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_notes.size() == 0)
            begin
                $display("%0t unexpected word: quantized_cv %0d note_changed %0b",
                         $time, quantized_cv, note_changed);
                mismatch_count++;
            end
            else
            begin
                want = pending_notes.pop_front();
                if (quantized_cv !== want.q)
                begin
                    $display("%0t quantized_cv mismatch: expected %0d, got %0d",
                             $time, want.q, quantized_cv);
                    mismatch_count++;
                end
                if (note_changed !== want.changed)
                begin
                    $display("%0t note_changed mismatch: expected %0b, got %0b",
                             $time, want.changed, note_changed);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no word moved for %0d cycles", $time, idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        cv_word_t w;
        cv_word_t prev;
        note_t    want;
        int       pass_no;
        int       set_no;
        int       k;
        int       v;
        int       so;
        int       tr;
        int       th;
        bit       tm;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = REG_SCALE_OFFSET;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        pitch_cv     = '0;
        scale_cv     = '0;
        transpose_cv = '0;
        trigger_cv   = '0;
        out_ready    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 20;
        recv_stall_pct = 80;
        foreach (opening_plan[r])
        begin
            if (opening_plan[r].kind == ROW_REG)
            begin
                drain_pipe();
                write_reg(cfg_addr_t'(opening_plan[r].f0), 16'(opening_plan[r].f1));
            end
            else
            begin
                w.pitch      = 16'(opening_plan[r].f0);
                w.scv        = 16'(opening_plan[r].f1);
                w.tcv        = 16'(opening_plan[r].f2);
                w.trig       = 16'(opening_plan[r].f3);
                want.q       = 16'(opening_plan[r].want_q);
                want.changed = opening_plan[r].want_chg;
                push_word(w, opening_plan[r].typed, want);
            end
        end

        prev = w;
        for (pass_no = 0; pass_no < 3; pass_no++)
        begin
            send_idle_pct  = (pass_no == 0) ? 20 : ((pass_no == 1) ? 80 : 0);
            recv_stall_pct = (pass_no == 0) ? 80 : ((pass_no == 1) ? 20 : 0);
            for (set_no = 0; set_no < SETS_PER_PASS; set_no++)
            begin
                case (set_no)
                    0:       begin so = 0;     tr = 0;      th = 2048;   end
                    1:       begin so = 32767; tr = 32767;  th = 32767;  end
                    2:       begin so = 0;     tr = -32768; th = -32768; end
                    default:
                    begin
                        so = ($urandom_range(3) == 0) ? $urandom_range(32767)
                                                      : $urandom_range(8191);
                        tr = $urandom_range(1) ? int'($urandom_range(16383)) - 8192
                                               : int'($urandom_range(65535)) - 32768;
                        th = int'($urandom_range(65535)) - 32768;
                    end
                endcase
                tm = (set_no % 2 == 1) || (set_no == 4);
                drain_pipe();
                write_reg(REG_SCALE_OFFSET, 16'(so));
                write_reg(REG_TRANSPOSE_OFFSET, 16'(tr));
                write_reg(REG_GATE_THRESHOLD, 16'(th));
                write_reg(REG_TRIGGER_CONNECTED, 16'(tm));

                for (k = 0; k < WORDS_PER_SET; k++)
                begin
                    // hold the previous pitch now and then so unchanged notes occur
                    if ($urandom_range(4) == 0)
                        w = prev;
                    else
                    begin
                        w.pitch = $urandom_range(1) ? 16'($urandom_range(65535))
                                                    : 16'(int'($urandom_range(16383)) - 8192);
                        if ($urandom_range(3) == 0)
                            w.scv = 16'($urandom_range(65535));
                        else
                        begin
                            v = int'($urandom_range(36863)) - 4096 - so;
                            w.scv = 16'((v < -32768) ? -32768 : v);
                        end
                        w.tcv = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                         : 16'(int'($urandom_range(4095)) - 2048);
                    end
                    if (tm)
                    begin
                        // keep the trigger around the threshold to make rising edges
                        case ($urandom_range(3))
                            0:       v = th;
                            1:       v = (th > -32768) ? th - 1 : th;
                            2:       v = 32767;
                            default: v = int'($urandom_range(65535)) - 32768;
                        endcase
                    end
                    else
                        v = int'($urandom_range(65535)) - 32768;
                    w.trig       = 16'(v);
                    want.q       = '0;
                    want.changed = 1'b0;
                    push_word(w, 1'b0, want);
                    prev = w;
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_notes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/csq_pkg.sv
rtl/cv_scale_quantizer_unit.sv
tb/tb_top.sv
